@@ rtl/tied_pkg.sv @@
// Package for the terminal input escape decoder.
// Holds sizes, byte codes, register indexes and the control/status types.
// No dependencies.
package tied_pkg;

	localparam int BUFFER_DEPTH = 64;
	localparam int MAX_RESULTS  = 64;
	localparam int EVT_CNT_W    = $clog2(MAX_RESULTS + 1);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [7:0] BYTE_ESC   = 8'h1b;
	localparam logic [7:0] BYTE_CR    = 8'h0d;
	localparam logic [7:0] BYTE_LBR   = 8'h5b;
	localparam logic [7:0] BYTE_LT    = 8'h3c;
	localparam logic [7:0] BYTE_SEMI  = 8'h3b;
	localparam logic [7:0] BYTE_M_UP  = 8'h4d;
	localparam logic [7:0] BYTE_M_LO  = 8'h6d;
	localparam logic [7:0] BYTE_A     = 8'h41;
	localparam logic [7:0] BYTE_B     = 8'h42;
	localparam logic [7:0] BYTE_C     = 8'h43;
	localparam logic [7:0] BYTE_D     = 8'h44;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_NINE  = 8'h39;
	localparam logic [7:0] FINAL_LO   = 8'h40;
	localparam logic [7:0] FINAL_HI   = 8'h7e;
	localparam logic [7:0] PRINT_LO   = 8'd32;
	localparam logic [7:0] PRINT_HI   = 8'd126;
	localparam logic [5:0] MOUSE_MIN  = 6'd6;

	localparam logic [CFG_IDX_W-1:0] CFG_KEY_UP       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_DOWN     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_RIGHT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEFT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_ESCAPE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LINEFEED = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DSTART,
		ST_LOAD,
		ST_B0,
		ST_B1,
		ST_B2,
		ST_MSCAN,
		ST_CSCAN,
		ST_EMIT,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		EV_BYTE,
		EV_ESC,
		EV_CSI,
		EV_MOUSE
	} ev_src_t;

	typedef struct packed {
		logic    push;
		logic    off_clr;
		logic    off_inc;
		logic    drop_one;
		logic    drop_upto;
		logic    drop_all;
		logic    par_clr;
		logic    par_step;
		logic    par_mouse;
		logic    build;
		ev_src_t src;
		logic    emit;
		logic    flush;
	} cmd_t;

	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic cnt_two;
		logic cnt_ge6;
		logic full;
		logic off_last;
		logic is_esc;
		logic is_lbr;
		logic is_lt;
		logic is_mterm;
		logic is_final;
		logic mouse_ok;
		logic csi_ok;
		logic ev_valid;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic        event_last;
		logic        event_kind;
		logic [15:0] key_value;
		logic        printable;
		logic [7:0]  ascii_char;
		logic [2:0]  modifier_mask;
		logic [15:0] pointer_x;
		logic [15:0] pointer_y;
		logic        pointer_moved;
		logic [6:0]  mouse_flags;
	} ev_t;

endpackage

@@ rtl/tied_byte_if.sv @@
// Input byte channel of the terminal input escape decoder.
// Valid/ready handshake; no dependencies.
interface tied_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       read_end;

	modport source (output valid, output in_byte, output read_end, input ready);
	modport sink (input valid, input in_byte, input read_end, output ready);
endinterface

@@ rtl/tied_event_if.sv @@
// Event channel of the terminal input escape decoder.
// Valid/ready handshake; no dependencies.
interface tied_event_if;
	logic        valid;
	logic        ready;
	logic        event_last;
	logic        event_kind;
	logic [15:0] key_value;
	logic        printable;
	logic [7:0]  ascii_char;
	logic [2:0]  modifier_mask;
	logic [15:0] pointer_x;
	logic [15:0] pointer_y;
	logic        pointer_moved;
	logic [6:0]  mouse_flags;

	modport source (output valid, output event_last, output event_kind, output key_value,
		output printable, output ascii_char, output modifier_mask, output pointer_x,
		output pointer_y, output pointer_moved, output mouse_flags, input ready);
	modport sink (input valid, input event_last, input event_kind, input key_value,
		input printable, input ascii_char, input modifier_mask, input pointer_x,
		input pointer_y, input pointer_moved, input mouse_flags, output ready);
endinterface

@@ rtl/tied_ctrl.sv @@
// Controller of the terminal input escape decoder: sequences byte fetches,
// parse steps, drops and event hand-off. Depends on tied_pkg.
module tied_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_read_end,
	output logic          in_ready,
	input  tied_pkg::sts_t sts,
	output tied_pkg::cmd_t cmd
);

	tied_pkg::state_t state_q, state_d;
	tied_pkg::state_t phase_q, phase_d;
	logic [tied_pkg::EVT_CNT_W-1:0] n_q, n_d;
	logic nm_q, nm_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tied_pkg::ST_IDLE;
			phase_q <= tied_pkg::ST_B0;
			n_q     <= '0;
			nm_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			n_q     <= n_d;
			nm_q    <= nm_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		phase_d  = phase_q;
		n_d      = n_q;
		nm_d     = nm_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tied_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.push = 1'b1;
					if (in_read_end) begin
						n_d     = '0;
						nm_d    = 1'b0;
						state_d = tied_pkg::ST_DSTART;
					end
				end
			end
			tied_pkg::ST_DSTART: begin
				if (sts.cnt_zero) begin
					state_d = tied_pkg::ST_FLUSH;
				end else begin
					cmd.off_clr = 1'b1;
					phase_d     = tied_pkg::ST_B0;
					state_d     = tied_pkg::ST_LOAD;
				end
			end
			tied_pkg::ST_LOAD: begin
				state_d = phase_q;
			end
			tied_pkg::ST_B0: begin
				if (!sts.is_esc || sts.cnt_one) begin
					cmd.build    = 1'b1;
					cmd.src      = sts.is_esc ? tied_pkg::EV_ESC : tied_pkg::EV_BYTE;
					cmd.drop_one = 1'b1;
					state_d      = tied_pkg::ST_EMIT;
				end else begin
					cmd.off_inc = 1'b1;
					phase_d     = tied_pkg::ST_B1;
					state_d     = tied_pkg::ST_LOAD;
				end
			end
			tied_pkg::ST_B1: begin
				if (!sts.is_lbr) begin
					cmd.build    = 1'b1;
					cmd.src      = tied_pkg::EV_ESC;
					cmd.drop_one = 1'b1;
					state_d      = tied_pkg::ST_EMIT;
				end else if (sts.cnt_two) begin
					state_d = tied_pkg::ST_FLUSH;
				end else begin
					cmd.off_inc = 1'b1;
					phase_d     = tied_pkg::ST_B2;
					state_d     = tied_pkg::ST_LOAD;
				end
			end
			tied_pkg::ST_B2: begin
				if (sts.is_lt) begin
					if (nm_q || !sts.cnt_ge6) begin
						state_d = tied_pkg::ST_FLUSH;
					end else begin
						cmd.off_inc = 1'b1;
						cmd.par_clr = 1'b1;
						phase_d     = tied_pkg::ST_MSCAN;
						state_d     = tied_pkg::ST_LOAD;
					end
				end else begin
					cmd.par_clr = 1'b1;
					phase_d     = tied_pkg::ST_CSCAN;
					state_d     = tied_pkg::ST_LOAD;
				end
			end
			tied_pkg::ST_MSCAN: begin
				if (sts.is_mterm) begin
					cmd.drop_upto = 1'b1;
					if (sts.mouse_ok) begin
						cmd.build = 1'b1;
						cmd.src   = tied_pkg::EV_MOUSE;
						state_d   = tied_pkg::ST_EMIT;
					end else begin
						nm_d    = 1'b1;
						state_d = tied_pkg::ST_DSTART;
					end
				end else begin
					cmd.par_step  = 1'b1;
					cmd.par_mouse = 1'b1;
					if (sts.off_last) begin
						if (sts.full) begin
							cmd.drop_one = 1'b1;
							nm_d         = 1'b1;
							state_d      = tied_pkg::ST_DSTART;
						end else begin
							state_d = tied_pkg::ST_FLUSH;
						end
					end else begin
						cmd.off_inc = 1'b1;
						state_d     = tied_pkg::ST_LOAD;
					end
				end
			end
			tied_pkg::ST_CSCAN: begin
				if (sts.is_final) begin
					cmd.drop_upto = 1'b1;
					if (sts.csi_ok) begin
						cmd.build = 1'b1;
						cmd.src   = tied_pkg::EV_CSI;
						state_d   = tied_pkg::ST_EMIT;
					end else begin
						state_d = tied_pkg::ST_FLUSH;
					end
				end else begin
					cmd.par_step = 1'b1;
					if (sts.off_last) begin
						cmd.drop_all = sts.full;
						state_d      = tied_pkg::ST_FLUSH;
					end else begin
						cmd.off_inc = 1'b1;
						state_d     = tied_pkg::ST_LOAD;
					end
				end
			end
			tied_pkg::ST_EMIT: begin
				if (!sts.ev_valid || sts.out_free) begin
					cmd.emit = 1'b1;
					n_d      = n_q + 1'b1;
					nm_d     = 1'b0;
					if (n_q == tied_pkg::EVT_CNT_W'(tied_pkg::MAX_RESULTS - 1)) begin
						state_d = tied_pkg::ST_FLUSH;
					end else begin
						state_d = tied_pkg::ST_DSTART;
					end
				end
			end
			tied_pkg::ST_FLUSH: begin
				if (!sts.ev_valid) begin
					state_d = tied_pkg::ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = tied_pkg::ST_IDLE;
				end
			end
		endcase
	end

endmodule

@@ rtl/tied_dp.sv @@
// Datapath of the terminal input escape decoder: circular byte buffer,
// number parser, key registers, event build and output registers.
// Depends on tied_pkg and tied_event_if.
module tied_dp #(
	parameter int BUFFER_DEPTH = tied_pkg::BUFFER_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        in_byte,
	input  logic                              cfg_we,
	input  logic [tied_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tied_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  tied_pkg::cmd_t                    cmd,
	output tied_pkg::sts_t                    sts,
	tied_event_if.source                      ev_ch
);

	localparam int HW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam logic [CW:0]   DEPTH_X = (CW + 1)'(BUFFER_DEPTH);
	localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

	function automatic logic [HW-1:0] wrap_add(logic [HW-1:0] a, logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW + 1)'(a) + (CW + 1)'(b);
		if (s >= DEPTH_X) s = s - DEPTH_X;
		return s[HW-1:0];
	endfunction

	function automatic logic [15:0] sat_acc(logic [15:0] v, logic [7:0] b);
		logic [19:0] w;
		w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, b[3:0]};
		return (w > 20'd65535) ? 16'hffff : w[15:0];
	endfunction

	function automatic logic [6:0] btn_flags(logic [15:0] btn, logic release_q);
		logic [6:0] f;
		f = '0;
		if (btn[6]) begin
			f = btn[0] ? 7'h02 : 7'h01;
		end else begin
			case (btn[1:0])
				2'd2: f = release_q ? 7'h40 : (btn[5] ? 7'h20 : 7'h60);
				2'd0, 2'd3: begin
					if (release_q || btn[1:0] == 2'd3) f = btn[5] ? 7'h08 : 7'h18;
					else f = 7'h04;
				end
				default: f = '0;
			endcase
		end
		return f;
	endfunction

	logic [7:0]    mem [BUFFER_DEPTH];
	logic [7:0]    rd_byte_q;
	logic [HW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] off_q;
	logic [HW-1:0] rd_addr;
	logic [HW-1:0] wr_addr;
	logic [CW-1:0] upto;

	logic [15:0] cur_q, v0_q, v1_q;
	logic        have_q, bad_q;
	logic [1:0]  nf_q;

	logic [15:0] key_up_q, key_down_q, key_right_q, key_left_q, key_esc_q, key_lf_q;
	logic [15:0] prev_x_q, prev_y_q;

	tied_pkg::ev_t nev_d, nev_q, ev_q, out_q;
	logic          ev_valid_q, out_valid_q;

	logic        is_digit, is_semi;
	logic [15:0] code;
	logic        params_ok;
	logic        full;

	assign full    = (count_q == DEPTH_C);
	assign rd_addr = wrap_add(head_q, off_q);
	assign wr_addr = wrap_add(head_q, count_q);
	assign upto    = off_q + 1'b1;

	assign is_digit = rd_byte_q >= tied_pkg::BYTE_ZERO && rd_byte_q <= tied_pkg::BYTE_NINE;
	assign is_semi  = rd_byte_q == tied_pkg::BYTE_SEMI;

	always_comb begin
		unique case (rd_byte_q)
			tied_pkg::BYTE_A: code = key_up_q;
			tied_pkg::BYTE_B: code = key_down_q;
			tied_pkg::BYTE_C: code = key_right_q;
			tied_pkg::BYTE_D: code = key_left_q;
			default:          code = '0;
		endcase
	end

	// a trailing ';' is an error; one parameter must be 1, two or more end in 2..8
	always_comb begin
		params_ok = !bad_q && !(nf_q != 2'd0 && !have_q);
		if (have_q) begin
			if (nf_q == 2'd0) params_ok = params_ok && cur_q == 16'd1;
			else params_ok = params_ok && cur_q >= 16'd2 && cur_q <= 16'd8;
		end
	end

	always_comb begin
		sts.cnt_zero = count_q == '0;
		sts.cnt_one  = count_q == CW'(1);
		sts.cnt_two  = count_q == CW'(2);
		sts.cnt_ge6  = count_q >= CW'(tied_pkg::MOUSE_MIN);
		sts.full     = full;
		sts.off_last = upto == count_q;
		sts.is_esc   = rd_byte_q == tied_pkg::BYTE_ESC;
		sts.is_lbr   = rd_byte_q == tied_pkg::BYTE_LBR;
		sts.is_lt    = rd_byte_q == tied_pkg::BYTE_LT;
		sts.is_mterm = rd_byte_q == tied_pkg::BYTE_M_UP || rd_byte_q == tied_pkg::BYTE_M_LO;
		sts.is_final = rd_byte_q >= tied_pkg::FINAL_LO && rd_byte_q <= tied_pkg::FINAL_HI;
		sts.mouse_ok = !bad_q && nf_q == 2'd2 && have_q;
		sts.csi_ok   = code != '0 && params_ok;
		sts.ev_valid = ev_valid_q;
		sts.out_free = !out_valid_q || ev_ch.ready;
	end

	always_comb begin
		nev_d = '0;
		unique case (cmd.src)
			tied_pkg::EV_BYTE: begin
				nev_d.key_value = (rd_byte_q == tied_pkg::BYTE_CR) ? key_lf_q : {8'h00, rd_byte_q};
				nev_d.printable = rd_byte_q >= tied_pkg::PRINT_LO &&
					rd_byte_q <= tied_pkg::PRINT_HI;
				nev_d.ascii_char = nev_d.printable ? rd_byte_q : 8'h00;
			end
			tied_pkg::EV_ESC: begin
				nev_d.key_value = key_esc_q;
			end
			tied_pkg::EV_CSI: begin
				nev_d.key_value = code;
				if (nf_q != 2'd0 && have_q) nev_d.modifier_mask = 3'(cur_q - 16'd1);
			end
			tied_pkg::EV_MOUSE: begin
				nev_d.event_kind    = 1'b1;
				nev_d.pointer_x     = (v1_q == '0) ? '0 : v1_q - 16'd1;
				nev_d.pointer_y     = (cur_q == '0) ? '0 : cur_q - 16'd1;
				nev_d.pointer_moved = nev_d.pointer_x != prev_x_q || nev_d.pointer_y != prev_y_q;
				nev_d.mouse_flags   = btn_flags(v0_q, rd_byte_q == tied_pkg::BYTE_M_LO);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.push && !full) mem[wr_addr] <= in_byte;
		rd_byte_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			off_q   <= '0;
		end else begin
			if (cmd.push && !full) count_q <= count_q + 1'b1;
			if (cmd.drop_one) begin
				head_q  <= wrap_add(head_q, CW'(1));
				count_q <= count_q - 1'b1;
			end
			if (cmd.drop_upto) begin
				head_q  <= wrap_add(head_q, upto);
				count_q <= count_q - upto;
			end
			if (cmd.drop_all) count_q <= '0;
			if (cmd.off_clr) off_q <= '0;
			if (cmd.off_inc) off_q <= upto;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.par_clr) begin
			cur_q  <= '0;
			have_q <= 1'b0;
			nf_q   <= '0;
			bad_q  <= 1'b0;
		end else if (cmd.par_step) begin
			if (is_digit) begin
				cur_q  <= sat_acc(cur_q, rd_byte_q);
				have_q <= 1'b1;
			end else if (is_semi && have_q && !(cmd.par_mouse && nf_q == 2'd2)) begin
				if (nf_q == 2'd0) v0_q <= cur_q;
				if (nf_q == 2'd1) v1_q <= cur_q;
				if (nf_q != 2'd2) nf_q <= nf_q + 2'd1;
				have_q <= 1'b0;
				cur_q  <= '0;
			end else begin
				bad_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_up_q    <= 16'd256;
			key_down_q  <= 16'd257;
			key_right_q <= 16'd258;
			key_left_q  <= 16'd259;
			key_esc_q   <= 16'd27;
			key_lf_q    <= 16'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tied_pkg::CFG_KEY_UP:       key_up_q    <= cfg_data;
				tied_pkg::CFG_KEY_DOWN:     key_down_q  <= cfg_data;
				tied_pkg::CFG_KEY_RIGHT:    key_right_q <= cfg_data;
				tied_pkg::CFG_KEY_LEFT:     key_left_q  <= cfg_data;
				tied_pkg::CFG_KEY_ESCAPE:   key_esc_q   <= cfg_data;
				tied_pkg::CFG_KEY_LINEFEED: key_lf_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= 16'hffff;
			prev_y_q    <= 16'hffff;
			ev_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.build && cmd.src == tied_pkg::EV_MOUSE) begin
				prev_x_q <= nev_d.pointer_x;
				prev_y_q <= nev_d.pointer_y;
			end
			if (cmd.flush || (cmd.emit && ev_valid_q)) out_valid_q <= 1'b1;
			else if (ev_ch.ready) out_valid_q <= 1'b0;
			if (cmd.flush) ev_valid_q <= 1'b0;
			else if (cmd.emit) ev_valid_q <= 1'b1;
		end
	end

	// held event goes out once the next decode outcome tells whether it is the last
	always_ff @(posedge clk) begin
		if (cmd.build) nev_q <= nev_d;
		if (cmd.emit) ev_q <= nev_q;
		if (cmd.flush) out_q <= tied_pkg::ev_t'({1'b1, ev_q[$bits(tied_pkg::ev_t)-2:0]});
		else if (cmd.emit && ev_valid_q) out_q <= ev_q;
	end

	assign ev_ch.valid         = out_valid_q;
	assign ev_ch.event_last    = out_q.event_last;
	assign ev_ch.event_kind    = out_q.event_kind;
	assign ev_ch.key_value     = out_q.key_value;
	assign ev_ch.printable     = out_q.printable;
	assign ev_ch.ascii_char    = out_q.ascii_char;
	assign ev_ch.modifier_mask = out_q.modifier_mask;
	assign ev_ch.pointer_x     = out_q.pointer_x;
	assign ev_ch.pointer_y     = out_q.pointer_y;
	assign ev_ch.pointer_moved = out_q.pointer_moved;
	assign ev_ch.mouse_flags   = out_q.mouse_flags;

endmodule

@@ rtl/terminal_input_escape_decoder.sv @@
// Top level of the terminal input escape decoder: controller plus datapath.
// Depends on tied_pkg, tied_byte_if, tied_event_if, tied_ctrl and tied_dp.
//
//   channel    direction  handshake          payload
//   byte_ch    in         valid/ready        in_byte, read_end
//   event_ch   out        valid/ready        event fields
//   cfg        in         cfg_we, no wait    cfg_index, cfg_data
//
// A byte without read_end is just pushed into the buffer. After a read end the
// buffer is decoded from the front; each byte examined is first fetched through
// the registered buffer read port, and each event then passes the emit step.
// Reset leaves the buffer empty and the key codes at their defaults.
// Each event is held back until the next decode outcome is known; a stalled
// event port holds the decoder in its emit or flush step, and no request is
// taken on the byte port until decoding has finished.
module terminal_input_escape_decoder #(
	parameter int BUFFER_DEPTH = tied_pkg::BUFFER_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	tied_byte_if.sink                       byte_ch,
	tied_event_if.source                    event_ch,
	input  logic                            cfg_we,
	input  logic [tied_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tied_pkg::CFG_DATA_W-1:0] cfg_data
);

	tied_pkg::cmd_t cmd;
	tied_pkg::sts_t sts;
	logic           in_ready;

	assign byte_ch.ready = in_ready;

	tied_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (byte_ch.valid),
		.in_read_end (byte_ch.read_end),
		.in_ready    (in_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	tied_dp #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (byte_ch.in_byte),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.ev_ch     (event_ch)
	);

`ifndef ASSERT_OFF
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.ev_valid |-> sts.out_free)
		else $error("event overwritten in output register");

	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |=> event_ch.valid && event_ch.event_last)
		else $error("final event of a read not marked last");

	a_drop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop_upto || cmd.drop_one |-> !sts.cnt_zero)
		else $error("drop from empty buffer");

	a_push_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !(cmd.emit || cmd.flush || cmd.build))
		else $error("byte taken while decoding");
`endif

endmodule
